// ===== rtl/ufd_pkg.sv =====
package ufd_pkg;

    // Error codes of a result word; the last code is internal only.
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_LEAD  = 3'd1;
    localparam logic [2:0] ERR_BAD_CONT  = 3'd2;
    localparam logic [2:0] ERR_OVERLONG  = 3'd3;
    localparam logic [2:0] ERR_SURROGATE = 3'd4;
    localparam logic [2:0] ERR_ABOVE_MAX = 3'd5;
    localparam logic [2:0] ERR_TOO_LONG  = 3'd6;
    localparam logic [2:0] DEC_NEED_MORE = 3'd7;

    localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
    localparam logic [20:0] CP_MAX         = 21'h10FFFF;
    localparam logic [20:0] SURR_LO        = 21'h00D800;
    localparam logic [20:0] SURR_HI        = 21'h00DFFF;

    localparam int IN_DEPTH_DEF  = 2;
    localparam int OUT_DEPTH_DEF = 2;

    typedef struct packed {
        logic       is_ascii;
        logic       is_cont;
        logic [2:0] seq_len;
    } byte_class_t;

    typedef struct packed {
        logic [7:0]  byte_val;
        byte_class_t cls;
        logic        last;
    } in_word_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  error_kind;
        logic        last_of_run;
    } result_t;

    function automatic byte_class_t classify(input logic [7:0] b);
        byte_class_t c;
        c.is_ascii = ~b[7];
        c.is_cont  = (b[7:6] == 2'b10);
        if (b[7:6] != 2'b11)
        begin
            c.seq_len = 3'd1;
        end
        else if (b[5] == 1'b0)
        begin
            c.seq_len = 3'd2;
        end
        else if (b[4] == 1'b0)
        begin
            c.seq_len = 3'd3;
        end
        else if (b[3] == 1'b0)
        begin
            c.seq_len = 3'd4;
        end
        else
        begin
            c.seq_len = 3'd5;
        end
        return c;
    endfunction

endpackage

// ===== rtl/utf8_stream_decoder.sv =====
// Channel   Handshake           Payload
// input     push / full         in_byte[7:0], stream_end
// result    pop / empty         code_point[20:0], error_kind[2:0], last_of_run
// config    cfg_valid/cfg_ready cfg_data (replace on error, reset 1)
//
// A byte passes an input queue, then the decoder makes one decode attempt per cycle
// while the result queue has room. A byte giving no result or one result needs a
// single attempt; each further result from an error rescan needs its own attempt.
// Reset clears the held bytes, the halt flag and both queues; replace mode is on.
// A full result queue stalls the decoder, which in turn lets the input queue fill.
module utf8_stream_decoder #(
    parameter int IN_DEPTH  = ufd_pkg::IN_DEPTH_DEF,
    parameter int OUT_DEPTH = ufd_pkg::OUT_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  in_byte,
    input  logic        stream_end,
    output logic        empty,
    input  logic        pop,
    output logic [20:0] code_point,
    output logic [2:0]  error_kind,
    output logic        last_of_run,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    localparam int RW = $bits(ufd_pkg::result_t);

    ufd_pkg::in_word_t q_data;
    logic              q_empty;
    logic              q_pop;
    logic              res_push;
    logic              res_full;
    ufd_pkg::result_t  res_word;
    ufd_pkg::result_t  head_word;
    logic [RW-1:0]     head_bits;

    assign cfg_ready = 1'b1;

    ufd_front #(
        .DEPTH (IN_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .in_byte    (in_byte),
        .stream_end (stream_end),
        .q_pop      (q_pop),
        .q_empty    (q_empty),
        .q_data     (q_data)
    );

    ufd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_empty  (q_empty),
        .in_data   (q_data),
        .in_pop    (q_pop),
        .out_full  (res_full),
        .out_push  (res_push),
        .out_data  (res_word)
    );

    ufd_fifo #(
        .WIDTH (RW),
        .DEPTH (OUT_DEPTH)
    ) u_result_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (RW'(res_word)),
        .full    (res_full),
        .pop     (pop),
        .rd_data (head_bits),
        .empty   (empty)
    );

    assign head_word   = ufd_pkg::result_t'(head_bits);
    assign code_point  = head_word.code_point;
    assign error_kind  = head_word.error_kind;
    assign last_of_run = head_word.last_of_run;

endmodule

// ===== rtl/ufd_fifo.sv =====
module ufd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/ufd_front.sv =====
module ufd_front #(
    parameter int DEPTH = ufd_pkg::IN_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         in_byte,
    input  logic               stream_end,
    input  logic               q_pop,
    output logic               q_empty,
    output ufd_pkg::in_word_t  q_data
);

    localparam int W = $bits(ufd_pkg::in_word_t);

    ufd_pkg::in_word_t wr_word;
    logic [W-1:0]      rd_bits;

    // Each byte is classified on the way in so the decoder sees ready-made flags.
    always_comb
    begin
        wr_word.byte_val = in_byte;
        wr_word.cls      = ufd_pkg::classify(in_byte);
        wr_word.last     = stream_end;
    end

    assign q_data = ufd_pkg::in_word_t'(rd_bits);

    ufd_fifo #(
        .WIDTH (W),
        .DEPTH (DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (W'(wr_word)),
        .full    (full),
        .pop     (q_pop),
        .rd_data (rd_bits),
        .empty   (q_empty)
    );

endmodule

// ===== rtl/ufd_back.sv =====
module ufd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic              cfg_data,
    input  logic              in_empty,
    input  ufd_pkg::in_word_t in_data,
    output logic              in_pop,
    input  logic              out_full,
    output logic              out_push,
    output ufd_pkg::result_t  out_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    typedef struct packed {
        logic [2:0]  kind;
        logic [20:0] cp;
        logic [2:0]  used;
    } dec_t;

    typedef ufd_pkg::byte_class_t [3:0] cls_arr_t;

    logic                 state_reg, state_next;
    logic [3:0][7:0]      buf_reg, buf_next;
    cls_arr_t             cls_reg, cls_next;
    logic [2:0]           cnt_reg, cnt_next;
    logic                 end_reg, end_next;
    logic                 halted_reg, halted_next;
    logic                 mode_reg;

    logic [3:0][7:0]      wb, sb;
    cls_arr_t             wc, sc;
    logic [2:0]           wn, rem, consumed, idx;
    logic                 wend;
    logic                 running, take_new, attempt, is_last;
    dec_t                 d1, d2;

    // One decode attempt on a buffer that starts at a sequence boundary.
    function automatic dec_t decode(input logic [3:0][7:0] b, input cls_arr_t c,
                                    input logic [2:0] n, input logic e);
        dec_t        r;
        logic        done;
        logic [2:0]  len;
        logic [20:0] d;
        logic        ovl;
        logic        sur;
        logic        big;
        r.kind = ufd_pkg::DEC_NEED_MORE;
        r.cp   = '0;
        r.used = 3'd1;
        done   = 1'b0;
        len    = c[0].seq_len;
        d      = '0;
        ovl    = 1'b0;
        sur    = 1'b0;
        big    = 1'b0;
        case (len)
            3'd2:
            begin
                d   = {10'd0, b[0][4:0], b[1][5:0]};
                ovl = (d[10:7] == 4'd0);
            end
            3'd3:
            begin
                d   = {5'd0, b[0][3:0], b[1][5:0], b[2][5:0]};
                ovl = (d[15:11] == 5'd0);
                sur = (d >= ufd_pkg::SURR_LO) && (d <= ufd_pkg::SURR_HI);
            end
            3'd4:
            begin
                d   = {b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
                ovl = (d[20:16] == 5'd0);
                big = (d > ufd_pkg::CP_MAX);
            end
            default:
            begin
                d = '0;
            end
        endcase
        if (c[0].is_ascii)
        begin
            r.kind = ufd_pkg::ERR_NONE;
            r.cp   = {13'd0, b[0]};
            done   = 1'b1;
        end
        else if (c[0].is_cont)
        begin
            r.kind = ufd_pkg::ERR_BAD_LEAD;
            done   = 1'b1;
        end
        // Continuation bytes are checked in arrival order.
        for (int i = 1; i < 4; i++)
        begin
            if (!done)
            begin
                if (3'(i) >= n)
                begin
                    r.kind = e ? ufd_pkg::ERR_TOO_LONG : ufd_pkg::DEC_NEED_MORE;
                    done   = 1'b1;
                end
                else if (!c[i].is_cont)
                begin
                    r.kind = ufd_pkg::ERR_BAD_CONT;
                    done   = 1'b1;
                end
                else if (3'(i) == len - 3'd1)
                begin
                    done = 1'b1;
                    if (ovl)
                    begin
                        r.kind = ufd_pkg::ERR_OVERLONG;
                    end
                    else if (sur)
                    begin
                        r.kind = ufd_pkg::ERR_SURROGATE;
                    end
                    else if (big)
                    begin
                        r.kind = ufd_pkg::ERR_ABOVE_MAX;
                    end
                    else
                    begin
                        r.kind = ufd_pkg::ERR_NONE;
                        r.cp   = d;
                        r.used = len;
                    end
                end
            end
        end
        // A lead announcing five or more bytes followed by three good ones.
        if (!done)
        begin
            r.kind = ufd_pkg::ERR_TOO_LONG;
        end
        return r;
    endfunction

    always_comb
    begin
        running  = (state_reg == ST_RUN);
        take_new = (state_reg == ST_IDLE) & ~in_empty & ~halted_reg & ~out_full;
        attempt  = (running & ~out_full) | take_new;
        in_pop   = ((state_reg == ST_IDLE) & ~in_empty & halted_reg) | take_new;

        // Working view: held bytes plus the new word when starting an item.
        for (int i = 0; i < 4; i++)
        begin
            if (running || (3'(i) < cnt_reg))
            begin
                wb[i] = buf_reg[i];
                wc[i] = cls_reg[i];
            end
            else
            begin
                wb[i] = in_data.byte_val;
                wc[i] = in_data.cls;
            end
        end
        wn   = running ? cnt_reg : cnt_reg + 3'd1;
        wend = running ? end_reg : in_data.last;

        d1 = decode(wb, wc, wn, wend);

        if (d1.kind == ufd_pkg::ERR_NONE)
        begin
            consumed = d1.used;
        end
        else if (mode_reg)
        begin
            consumed = 3'd1;
        end
        else
        begin
            consumed = wn;
        end
        rem = wn - consumed;

        for (int i = 0; i < 4; i++)
        begin
            idx = 3'(i) + consumed;
            if (idx < 3'd4)
            begin
                sb[i] = wb[idx[1:0]];
                sc[i] = wc[idx[1:0]];
            end
            else
            begin
                sb[i] = '0;
                sc[i] = '0;
            end
        end

        // Look ahead one attempt to know whether this result closes the run.
        d2      = decode(sb, sc, rem, wend);
        is_last = (rem == 3'd0) || (d2.kind == ufd_pkg::DEC_NEED_MORE);

        state_next  = state_reg;
        buf_next    = buf_reg;
        cls_next    = cls_reg;
        cnt_next    = cnt_reg;
        end_next    = end_reg;
        halted_next = halted_reg;
        out_push    = 1'b0;
        out_data.code_point  = d1.cp;
        out_data.error_kind  = d1.kind;
        out_data.last_of_run = is_last;

        if ((state_reg == ST_IDLE) && !in_empty && halted_reg)
        begin
            if (in_data.last)
            begin
                halted_next = 1'b0;
                cnt_next    = 3'd0;
            end
        end
        else if (attempt)
        begin
            end_next = wend;
            if (d1.kind == ufd_pkg::DEC_NEED_MORE)
            begin
                buf_next   = wb;
                cls_next   = wc;
                cnt_next   = wn;
                state_next = ST_IDLE;
            end
            else
            begin
                out_push   = 1'b1;
                buf_next   = sb;
                cls_next   = sc;
                cnt_next   = rem;
                state_next = is_last ? ST_IDLE : ST_RUN;
                if (d1.kind != ufd_pkg::ERR_NONE)
                begin
                    if (mode_reg)
                    begin
                        out_data.code_point = ufd_pkg::CP_REPLACEMENT;
                    end
                    else
                    begin
                        out_data.code_point = '0;
                        halted_next         = ~wend;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            end_reg    <= 1'b0;
            halted_reg <= 1'b0;
            mode_reg   <= 1'b1;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            end_reg    <= end_next;
            halted_reg <= halted_next;
            if (cfg_valid)
            begin
                mode_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
        cls_reg <= cls_next;
    end

endmodule
